>>> hdl/assert_macros.svh
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/sysio_pkg.sv
package sysio_pkg;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColorModel     = 2'd0,
    CfgFirstGen       = 2'd1,
    CfgSecondGenColor = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] AddrDmaSrc0   = 16'h0040;
  localparam logic [15:0] AddrDmaSrc1   = 16'h0041;
  localparam logic [15:0] AddrDmaSrc2   = 16'h0042;
  localparam logic [15:0] AddrDmaTgt0   = 16'h0044;
  localparam logic [15:0] AddrDmaTgt1   = 16'h0045;
  localparam logic [15:0] AddrDmaLen0   = 16'h0046;
  localparam logic [15:0] AddrDmaLen1   = 16'h0047;
  localparam logic [15:0] AddrDmaCtrl   = 16'h0048;
  localparam logic [15:0] AddrSystem    = 16'h0062;
  localparam logic [15:0] AddrCartFlags = 16'h00a0;
  localparam logic [15:0] AddrIntBase   = 16'h00b0;
  localparam logic [15:0] AddrIntEnable = 16'h00b2;
  localparam logic [15:0] AddrIntStatus = 16'h00b4;
  localparam logic [15:0] AddrKeypad    = 16'h00b5;
  localparam logic [15:0] AddrIntAck    = 16'h00b6;
  localparam logic [15:0] AddrNmi       = 16'h00b7;

  localparam logic [7:0] BaseMask = 8'hf8;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [3:0]  key_lines;
    logic [7:0]  irq_raise;
    logic [7:0]  irq_level;
  } sysio_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dma_start;
    logic       power_off;
    logic [2:0] key_select;
    logic [7:0] irq_pending;
  } sysio_out_t;

  typedef struct packed {
    logic              we;
    logic [CfgIdxW-1:0] idx;
    logic              data;
  } sysio_cfg_t;

endpackage

>>> hdl/sysio_regs.sv
module sysio_regs import sysio_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sysio_cfg_t cfg_i,
  input  logic       push_i,
  input  sysio_in_t  item_i,
  output sysio_out_t res_o
);

  logic        color_model_q, first_gen_q, second_gen_color_q;
  logic [19:0] dma_source_q, dma_source_d;
  logic [15:0] dma_target_q, dma_target_d;
  logic [15:0] dma_length_q, dma_length_d;
  logic        dma_direction_q, dma_direction_d;
  logic        dma_enabled_q, dma_enabled_d;
  logic        cart_enable_q, cart_enable_d;
  logic        rom_width_q, rom_width_d;
  logic        rom_wait_q, rom_wait_d;
  logic [7:0]  vector_base_q, vector_base_d;
  logic [7:0]  irq_enable_q, irq_enable_d;
  logic [7:0]  irq_status_q, irq_status_d;
  logic [2:0]  matrix_select_q, matrix_select_d;
  logic        nmi_low_battery_q, nmi_low_battery_d;

  logic [7:0]  status_raised;
  logic [7:0]  rd;
  logic        start, poff;
  logic        is_write;
  logic [7:0]  d;

  function automatic logic [2:0] top_index(logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_model_q      <= 1'b1;
      first_gen_q        <= 1'b0;
      second_gen_color_q <= 1'b0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CfgColorModel:     color_model_q      <= cfg_i.data;
        CfgFirstGen:       first_gen_q        <= cfg_i.data;
        CfgSecondGenColor: second_gen_color_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_write        = (item_i.op == OpWrite);
    d               = item_i.write_data;
    status_raised   = irq_status_q | item_i.irq_raise;
    dma_source_d    = dma_source_q;
    dma_target_d    = dma_target_q;
    dma_length_d    = dma_length_q;
    dma_direction_d = dma_direction_q;
    dma_enabled_d   = dma_enabled_q;
    cart_enable_d   = cart_enable_q;
    rom_width_d     = rom_width_q;
    rom_wait_d      = rom_wait_q;
    vector_base_d   = vector_base_q;
    irq_enable_d    = irq_enable_q;
    irq_status_d    = status_raised;
    matrix_select_d = matrix_select_q;
    nmi_low_battery_d = nmi_low_battery_q;
    rd    = 8'h00;
    start = 1'b0;
    poff  = 1'b0;

    if (!is_write) begin
      unique case (item_i.address)
        AddrDmaSrc0: if (color_model_q) rd = dma_source_q[7:0];
        AddrDmaSrc1: if (color_model_q) rd = dma_source_q[15:8];
        AddrDmaSrc2: if (color_model_q) rd = {4'h0, dma_source_q[19:16]};
        AddrDmaTgt0: if (color_model_q) rd = dma_target_q[7:0];
        AddrDmaTgt1: if (color_model_q) rd = dma_target_q[15:8];
        AddrDmaLen0: if (color_model_q) rd = dma_length_q[7:0];
        AddrDmaLen1: if (color_model_q) rd = dma_length_q[15:8];
        AddrDmaCtrl: if (color_model_q) rd = {dma_enabled_q, 6'h00, dma_direction_q};
        AddrSystem:    rd = {second_gen_color_q, 7'h00};
        AddrCartFlags: rd = {4'h8, rom_wait_q, rom_width_q, ~first_gen_q, cart_enable_q};
        AddrIntBase:   rd = vector_base_q | {5'h00, top_index(status_raised)};
        AddrIntEnable: rd = irq_enable_q;
        AddrIntStatus: rd = status_raised | (item_i.irq_level & irq_enable_q);
        AddrKeypad:    rd = {1'b0, matrix_select_q, item_i.key_lines};
        AddrNmi:       rd = {3'h0, nmi_low_battery_q, 4'h0};
        default: ;
      endcase
    end else begin
      unique case (item_i.address)
        AddrDmaSrc0: if (color_model_q) dma_source_d[7:0]   = {d[7:1], 1'b0};
        AddrDmaSrc1: if (color_model_q) dma_source_d[15:8]  = d;
        AddrDmaSrc2: if (color_model_q) dma_source_d[19:16] = d[3:0];
        AddrDmaTgt0: if (color_model_q) dma_target_d[7:0]   = {d[7:1], 1'b0};
        AddrDmaTgt1: if (color_model_q) dma_target_d[15:8]  = d;
        AddrDmaLen0: if (color_model_q) dma_length_d[7:0]   = {d[7:1], 1'b0};
        AddrDmaLen1: if (color_model_q) dma_length_d[15:8]  = d;
        AddrDmaCtrl: begin
          if (color_model_q) begin
            dma_direction_d = d[6];
            dma_enabled_d   = d[7];
            start           = d[7];
          end
        end
        AddrSystem: poff = !first_gen_q && d[0];
        AddrCartFlags: begin
          // enable bit is sticky once set
          cart_enable_d = cart_enable_q | d[0];
          rom_width_d   = d[2];
          rom_wait_d    = d[3];
        end
        AddrIntBase:   vector_base_d   = d & BaseMask;
        AddrIntEnable: irq_enable_d    = d;
        AddrKeypad:    matrix_select_d = d[6:4];
        AddrIntAck:    irq_status_d    = status_raised & ~d;
        AddrNmi:       nmi_low_battery_d = d[4];
        default: ;
      endcase
    end

    res_o.read_data   = rd;
    res_o.dma_start   = start;
    res_o.power_off   = poff;
    res_o.key_select  = matrix_select_d;
    res_o.irq_pending = irq_status_d | (item_i.irq_level & irq_enable_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_source_q      <= '0;
      dma_target_q      <= '0;
      dma_length_q      <= '0;
      dma_direction_q   <= 1'b0;
      dma_enabled_q     <= 1'b0;
      cart_enable_q     <= 1'b0;
      rom_width_q       <= 1'b0;
      rom_wait_q        <= 1'b0;
      vector_base_q     <= '0;
      irq_enable_q      <= '0;
      irq_status_q      <= '0;
      matrix_select_q   <= '0;
      nmi_low_battery_q <= 1'b0;
    end else if (push_i) begin
      dma_source_q      <= dma_source_d;
      dma_target_q      <= dma_target_d;
      dma_length_q      <= dma_length_d;
      dma_direction_q   <= dma_direction_d;
      dma_enabled_q     <= dma_enabled_d;
      cart_enable_q     <= cart_enable_d;
      rom_width_q       <= rom_width_d;
      rom_wait_q        <= rom_wait_d;
      vector_base_q     <= vector_base_d;
      irq_enable_q      <= irq_enable_d;
      irq_status_q      <= irq_status_d;
      matrix_select_q   <= matrix_select_d;
      nmi_low_battery_q <= nmi_low_battery_d;
    end
  end

endmodule

>>> hdl/sysio_outq.sv
module sysio_outq import sysio_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sysio_out_t data_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       ready_i,
  output sysio_out_t data_o
);

  sysio_out_t entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + 2'd1;
    else if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= data_i;
  end

endmodule

>>> hdl/system_io_interrupt_dma_registers.sv
// System I/O register block: DMA source/target/length and control, cartridge
// flags, interrupt base/enable/status/ack, keypad select, power-off and NMI.
// Each input transfer is one bus access; its result (read byte, DMA-start
// and power-off pulses, keypad select, pending interrupts) is produced
// combinationally by the register decode and lands in a two-entry result
// queue, so a new access is taken every cycle as long as the queue is not
// full, and the first result is visible in the next cycle. The DMA transfer
// itself is not performed here. Configuration writes take effect next cycle.
module system_io_interrupt_dma_registers import sysio_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sysio_in_t          in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sysio_out_t         out_data_o
);

  sysio_cfg_t cfg;
  sysio_out_t res;
  logic       push, full;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign in_ready_o = !full;
  assign push       = in_valid_i && in_ready_o;

  sysio_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .push_i (push),
    .item_i (in_data_i),
    .res_o  (res)
  );

  sysio_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

>>> hdl/sysio_checker.sv
`include "assert_macros.svh"

module sysio_checker import sysio_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input sysio_out_t out_data_o
);

  logic in_xfer;
  logic pulse_seen;
  logic pulse_clean;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign pulse_seen  = out_valid_o && (out_data_o.dma_start || out_data_o.power_off);
  assign pulse_clean = (out_data_o.read_data == 8'h00) &&
                       !(out_data_o.dma_start && out_data_o.power_off);

  // a stalled result stays offered
  `ASSERT_NXT(out_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // empty result queue never blocks an access
  `ASSERT_IMP(ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // an access into an empty queue shows its result next cycle
  `ASSERT_NXT(result_follows, clk_i, rst_ni, in_xfer && !out_valid_o, out_valid_o)

  // pulses come from writes only, which read zero and never raise both
  `ASSERT_IMP(pulse_on_write, clk_i, rst_ni, pulse_seen, pulse_clean)

endmodule

bind system_io_interrupt_dma_registers sysio_checker u_sysio_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
